/* hdl/mdt_pkg.sv */
// ---------------------------------------------------------------------------
// mdt_pkg
// Shared types and constants of the modular dot threshold counter.
// ---------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

  // Digit and register widths
  localparam int DIGIT_W = 8;
  localparam int QUERY_W = 31;
  localparam int TOTAL_W = 32;
  localparam int TCNT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Default parameter values
  localparam int MAX_DIGITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY = 2'd3;

  // Control of a bit-serial divider
  typedef struct packed {
    logic load;   // take a new dividend, clear remainder
    logic step;   // produce one quotient bit
    logic first;  // first step of a digit: start from a zero remainder
  } div_ctrl_t;

  // Control of the bit-serial modular multiplier
  typedef struct packed {
    logic load;   // take operands, clear product
    logic step;   // consume one multiplier bit
  } mul_ctrl_t;

endpackage

`default_nettype wire

/* hdl/mdt_divider.sv */
// ---------------------------------------------------------------------------
// mdt_divider
// Restoring divider by a small modulus, one quotient bit per cycle while step
// is asserted. The quotient stays in the shift register so the next digit can follow.
// ---------------------------------------------------------------------------
`default_nettype none

module mdt_divider #(
  parameter int DIV_W = 32
) (
  input  wire                             clk,
  input  wire mdt_pkg::div_ctrl_t         ctrl,
  input  wire [DIV_W-1:0]                 load_val,
  input  wire [mdt_pkg::DIGIT_W-1:0]      q,
  output logic [DIV_W-1:0]                quo,
  output logic [mdt_pkg::DIGIT_W-1:0]     rem
);

  logic [DIV_W-1:0]            quo_r, quo_nxt;
  logic [mdt_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [mdt_pkg::DIGIT_W-1:0] rem_use;
  logic [mdt_pkg::DIGIT_W:0]   rem_sh;
  logic [mdt_pkg::DIGIT_W:0]   rem_sub;
  logic                        ge;

  // Shift in the next dividend bit and trial-subtract the modulus
  always_comb begin
    rem_use = ctrl.first ? '0 : rem_r;
    rem_sh  = {rem_use, quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, q};
    ge      = (rem_sh >= {1'b0, q});
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (ctrl.load) begin
      quo_nxt = load_val;
      rem_nxt = '0;
    end else if (ctrl.step) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? rem_sub[mdt_pkg::DIGIT_W-1:0] : rem_sh[mdt_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

`default_nettype wire

/* hdl/mdt_modmul.sv */
// ---------------------------------------------------------------------------
// mdt_modmul
// Bit-serial modular multiplier: double-and-add modulo q, multiplier bits
// taken most significant first, one bit per cycle while step is asserted.
// ---------------------------------------------------------------------------
`default_nettype none

module mdt_modmul (
  input  wire                             clk,
  input  wire mdt_pkg::mul_ctrl_t         ctrl,
  input  wire [mdt_pkg::DIGIT_W-1:0]      md,
  input  wire [mdt_pkg::DIGIT_W-1:0]      qd,
  input  wire [mdt_pkg::DIGIT_W-1:0]      q,
  output logic [mdt_pkg::DIGIT_W-1:0]     prod
);

  logic [mdt_pkg::DIGIT_W-1:0] md_r, md_nxt;
  logic [mdt_pkg::DIGIT_W-1:0] qd_r, qd_nxt;
  logic [mdt_pkg::DIGIT_W-1:0] acc_r, acc_nxt;
  logic [mdt_pkg::DIGIT_W:0]   dbl;
  logic [mdt_pkg::DIGIT_W:0]   dbl_sub;
  logic [mdt_pkg::DIGIT_W-1:0] dbl_red;
  logic [mdt_pkg::DIGIT_W:0]   sum;
  logic [mdt_pkg::DIGIT_W:0]   sum_sub;
  logic [mdt_pkg::DIGIT_W-1:0] sum_red;

  // Double modulo q, then add the multiplicand modulo q when the bit is set
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_sub = dbl - {1'b0, q};
    dbl_red = (dbl >= {1'b0, q}) ? dbl_sub[mdt_pkg::DIGIT_W-1:0]
                                 : dbl[mdt_pkg::DIGIT_W-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, md_r};
    sum_sub = sum - {1'b0, q};
    sum_red = (sum >= {1'b0, q}) ? sum_sub[mdt_pkg::DIGIT_W-1:0]
                                 : sum[mdt_pkg::DIGIT_W-1:0];
    md_nxt  = md_r;
    qd_nxt  = qd_r;
    acc_nxt = acc_r;
    if (ctrl.load) begin
      md_nxt  = md;
      qd_nxt  = qd;
      acc_nxt = '0;
    end else if (ctrl.step) begin
      qd_nxt  = {qd_r[mdt_pkg::DIGIT_W-2:0], 1'b0};
      acc_nxt = qd_r[mdt_pkg::DIGIT_W-1] ? sum_red : dbl_red;
    end
  end

  always_ff @(posedge clk) begin
    md_r  <= md_nxt;
    qd_r  <= qd_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;

endmodule

`default_nettype wire

/* hdl/modular_dot_threshold_counter_unit.sv */
// Each request divides out the offset digit, then for each of t digits (t = clamped digit
//   count) divides, multiplies and adds, then reports; divider width D = max(WORD_BITS, 32).
// Throughput: one request at a time; in_tready rises together with out_tvalid when the
//   result is registered; the bit-serial dividers (one quotient bit per cycle) dominate.
// Reset (rst_n low, synchronous): counters clear, registers return to modulus 2,
//   digit count 1, threshold 1, query item 0; no result pending.
// ---------------------------------------------------------------------------
// modular_dot_threshold_counter_unit
// Splits each message word and the query item plus one into base-q digits,
// forms the modular dot product plus offset, compares against the threshold
// and keeps saturating match and message totals per batch.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_dot_threshold_counter_unit #(
  parameter int MAX_DIGITS = mdt_pkg::MAX_DIGITS_DEF,
  parameter int WORD_BITS  = mdt_pkg::WORD_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [mdt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [mdt_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [((WORD_BITS+7)/8)*8-1:0]       in_tdata,   // message_word
  input  wire                                 in_tlast,   // last_message
  // result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [2*mdt_pkg::TOTAL_W-1:0]       out_tdata,  // match_total, message_total
  output logic                                out_tuser,  // is_match
  output logic                                out_tlast   // batch_end
);

  localparam int DIV_W = (WORD_BITS > mdt_pkg::QUERY_W + 1) ? WORD_BITS
                                                           : mdt_pkg::QUERY_W + 1;
  localparam int BIT_CNT_W = $clog2(DIV_W);
  localparam int DIG_W = $clog2(MAX_DIGITS + 1);
  localparam int DW = mdt_pkg::DIGIT_W;
  localparam int TW = mdt_pkg::TOTAL_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_DIGIT = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // configuration registers
  logic [DW-1:0]                  modulus_r, modulus_nxt;
  logic [mdt_pkg::TCNT_W-1:0]     digit_count_r, digit_count_nxt;
  logic [DW-1:0]                  threshold_r, threshold_nxt;
  logic [mdt_pkg::QUERY_W-1:0]    query_r, query_nxt;

  // control and datapath registers
  logic [2:0]                     state_r, state_nxt;
  logic [BIT_CNT_W-1:0]           bit_cnt_r, bit_cnt_nxt;
  logic [DIG_W-1:0]               digit_r, digit_nxt;
  logic [DW-1:0]                  acc_r, acc_nxt;
  logic                           last_r, last_nxt;
  logic [TW-1:0]                  match_cnt_r, match_cnt_nxt;
  logic [TW-1:0]                  msg_cnt_r, msg_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_match_r, out_match_nxt;
  logic [TW-1:0]                  out_mtot_r, out_mtot_nxt;
  logic [TW-1:0]                  out_ntot_r, out_ntot_nxt;
  logic                           out_last_r, out_last_nxt;

  // combinational helpers
  logic [DW-1:0]                  q_eff;
  logic [DIG_W-1:0]               t_eff;
  logic                           in_acc;
  logic                           cfg_acc;
  logic                           out_free;
  logic                           hit;
  logic [TW-1:0]                  msg_inc;
  logic [TW-1:0]                  match_inc;
  logic [DW:0]                    add_sum;
  logic [DW:0]                    add_sub;
  logic [DIV_W-1:0]               msg_load;
  logic [DIV_W-1:0]               qv_load;
  logic [mdt_pkg::QUERY_W:0]      qv;

  mdt_pkg::div_ctrl_t             msg_ctrl;
  mdt_pkg::div_ctrl_t             qv_ctrl;
  mdt_pkg::mul_ctrl_t             mul_ctrl;
  logic [DIV_W-1:0]               msg_quo;
  logic [DIV_W-1:0]               qv_quo;
  logic [DW-1:0]                  msg_rem;
  logic [DW-1:0]                  qv_rem;
  logic [DW-1:0]                  prod;

  // Clamp the modulus and the digit count
  always_comb begin
    q_eff = (modulus_r < DW'(2)) ? DW'(2) : modulus_r;
    if (32'(digit_count_r) > 32'(MAX_DIGITS)) begin
      t_eff = DIG_W'(MAX_DIGITS);
    end else begin
      t_eff = DIG_W'(digit_count_r);
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Operands of the two dividers
  assign qv       = {1'b0, query_r} + (mdt_pkg::QUERY_W + 1)'(1);
  assign msg_load = DIV_W'(in_tdata[WORD_BITS-1:0]);
  assign qv_load  = DIV_W'(qv);

  mdt_divider #(
    .DIV_W (DIV_W)
  ) u_msg_div (
    .clk      (clk),
    .ctrl     (msg_ctrl),
    .load_val (msg_load),
    .q        (q_eff),
    .quo      (msg_quo),
    .rem      (msg_rem)
  );

  mdt_divider #(
    .DIV_W (DIV_W)
  ) u_qv_div (
    .clk      (clk),
    .ctrl     (qv_ctrl),
    .load_val (qv_load),
    .q        (q_eff),
    .quo      (qv_quo),
    .rem      (qv_rem)
  );

  mdt_modmul u_modmul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .md   (msg_rem),
    .qd   (qv_rem),
    .q    (q_eff),
    .prod (prod)
  );

  // Configuration register writes
  always_comb begin
    modulus_nxt     = modulus_r;
    digit_count_nxt = digit_count_r;
    threshold_nxt   = threshold_r;
    query_nxt       = query_r;
    if (cfg_acc) begin
      unique case (cfg_index)
        mdt_pkg::CFG_MODULUS:     modulus_nxt     = cfg_data[DW-1:0];
        mdt_pkg::CFG_DIGIT_COUNT: digit_count_nxt = cfg_data[mdt_pkg::TCNT_W-1:0];
        mdt_pkg::CFG_THRESHOLD:   threshold_nxt   = cfg_data[DW-1:0];
        mdt_pkg::CFG_QUERY:       query_nxt       = cfg_data[mdt_pkg::QUERY_W-1:0];
        default:                  ;
      endcase
    end
  end

  // Sequencer: divide out digits, multiply pairs, accumulate, then report
  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    digit_nxt     = digit_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    match_cnt_nxt = match_cnt_r;
    msg_cnt_nxt   = msg_cnt_r;
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_mtot_nxt  = out_mtot_r;
    out_ntot_nxt  = out_ntot_r;
    out_last_nxt  = out_last_r;

    msg_ctrl = '0;
    qv_ctrl  = '0;
    mul_ctrl = '0;

    add_sum   = {1'b0, acc_r} + {1'b0, prod};
    add_sub   = add_sum - {1'b0, q_eff};
    hit       = (acc_r >= threshold_r);
    msg_inc   = (msg_cnt_r == '1) ? msg_cnt_r : msg_cnt_r + TW'(1);
    match_inc = (match_cnt_r == '1) ? match_cnt_r : match_cnt_r + TW'(1);

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          msg_ctrl.load = 1'b1;
          qv_ctrl.load  = 1'b1;
          last_nxt      = in_tlast;
          digit_nxt     = '0;
          bit_cnt_nxt   = '0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        msg_ctrl.step  = 1'b1;
        msg_ctrl.first = (bit_cnt_r == '0);
        qv_ctrl.step   = (digit_r != '0);
        qv_ctrl.first  = (bit_cnt_r == '0);
        bit_cnt_nxt    = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        bit_cnt_nxt = '0;
        if (digit_r == '0) begin
          // lowest message digit is the offset
          acc_nxt = msg_rem;
          if (t_eff == '0) begin
            state_nxt = ST_DONE;
          end else begin
            digit_nxt = DIG_W'(1);
            state_nxt = ST_DIV;
          end
        end else begin
          mul_ctrl.load = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        bit_cnt_nxt   = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(DW - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        acc_nxt     = (add_sum >= {1'b0, q_eff}) ? add_sub[DW-1:0] : add_sum[DW-1:0];
        bit_cnt_nxt = '0;
        if (digit_r == t_eff) begin
          state_nxt = ST_DONE;
        end else begin
          digit_nxt = digit_r + DIG_W'(1);
          state_nxt = ST_DIV;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = hit;
          out_mtot_nxt  = hit ? match_inc : match_cnt_r;
          out_ntot_nxt  = msg_inc;
          out_last_nxt  = last_r;
          if (last_r) begin
            match_cnt_nxt = '0;
            msg_cnt_nxt   = '0;
          end else begin
            match_cnt_nxt = hit ? match_inc : match_cnt_r;
            msg_cnt_nxt   = msg_inc;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      match_cnt_r   <= '0;
      msg_cnt_r     <= '0;
      modulus_r     <= DW'(2);
      digit_count_r <= mdt_pkg::TCNT_W'(1);
      threshold_r   <= DW'(1);
      query_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      match_cnt_r   <= match_cnt_nxt;
      msg_cnt_r     <= msg_cnt_nxt;
      modulus_r     <= modulus_nxt;
      digit_count_r <= digit_count_nxt;
      threshold_r   <= threshold_nxt;
      query_r       <= query_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bit_cnt_r   <= bit_cnt_nxt;
    digit_r     <= digit_nxt;
    acc_r       <= acc_nxt;
    last_r      <= last_nxt;
    out_match_r <= out_match_nxt;
    out_mtot_r  <= out_mtot_nxt;
    out_ntot_r  <= out_ntot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ntot_r, out_mtot_r};
  assign out_tuser  = out_match_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
